// ===== hw/rtl/pscm_pkg.sv =====
// ----------------------------------------------------------------------------
// Proximity stopwatch mode control package
// Shared types, constants and helper functions for the mode control block.
// ----------------------------------------------------------------------------
package pscm_pkg;

   // Field widths
   localparam int unsigned WidthUsW    = 15;
   localparam int unsigned DistW       = 18;
   localparam int unsigned NearW       = 8;
   localparam int unsigned FarW        = 10;
   localparam int unsigned CountW      = 16;
   localparam int unsigned ModeW       = 2;
   localparam int unsigned CsrDataW    = 16;
   localparam int unsigned CsrIndexW   = 2;
   localparam int unsigned FracW       = 8;

   // Half the speed of sound in cm/us, scaled by 2^24 (8 fraction bits
   // of the result and 16 bits dropped after the product).
   localparam int unsigned DistMulW    = 19;
   localparam logic [DistMulW-1:0] DistMul = 19'd285456;
   localparam int unsigned ProdW       = WidthUsW + DistMulW;

   // Register reset values
   localparam logic [NearW-1:0]  NearReset         = 8'd10;
   localparam logic [FarW-1:0]   FarReset          = 10'd50;
   localparam logic [CountW-1:0] StopLockoutReset  = 16'd40;
   localparam logic [CountW-1:0] MeterLockoutReset = 16'd40;

   // Register indexes on the configuration port
   typedef enum logic [CsrIndexW-1:0] {
      CSR_NEAR_CM       = 2'd0,
      CSR_FAR_CM        = 2'd1,
      CSR_STOP_LOCKOUT  = 2'd2,
      CSR_METER_LOCKOUT = 2'd3
   } csr_index_type;

   // Mode codes as seen on the result channel
   localparam logic [ModeW-1:0] ModeCodeIdle   = 2'd0;
   localparam logic [ModeW-1:0] ModeCodeTiming = 2'd1;
   localparam logic [ModeW-1:0] ModeCodeMeter  = 2'd2;

   // Run mode state, one-hot
   typedef enum logic [2:0] {
      RUN_IDLE   = 3'b001,
      RUN_TIMING = 3'b010,
      RUN_METER  = 3'b100
   } run_mode_type;

   // Configuration register set
   typedef struct packed {
      logic [NearW-1:0]  near_cm;
      logic [FarW-1:0]   far_cm;
      logic [CountW-1:0] stop_lockout;
      logic [CountW-1:0] meter_lockout;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic [DistW-1:0] distance_q8;
      logic [ModeW-1:0] mode;
      logic             mode_changed;
   } result_type;

   // Absolute difference of two counter values, taken without wrap.
   function automatic logic [CountW-1:0] abs_diff(input logic [CountW-1:0] a,
                                                  input logic [CountW-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // Map the one-hot run mode to its result code.
   function automatic logic [ModeW-1:0] mode_code(input run_mode_type m);
      logic [ModeW-1:0] code;
      unique case (m)
         RUN_IDLE:   code = ModeCodeIdle;
         RUN_TIMING: code = ModeCodeTiming;
         RUN_METER:  code = ModeCodeMeter;
         default:    code = ModeCodeIdle;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/pscm_distance.sv =====
// ----------------------------------------------------------------------------
// Echo width to distance converter
// Scales the echo high time in microseconds to centimeters with 8 fraction
// bits by one constant multiplication and a fixed shift.
// ----------------------------------------------------------------------------
module pscm_distance (
   input  logic [pscm_pkg::WidthUsW-1:0] width_us,
   output logic [pscm_pkg::DistW-1:0]    distance_q8
);

   logic [pscm_pkg::ProdW-1:0] product;

   // The product of a 15-bit width and the 19-bit scale fits in 34 bits.
   assign product = pscm_pkg::ProdW'(width_us) * pscm_pkg::ProdW'(pscm_pkg::DistMul);

   // Drop 16 bits; the largest width still fits in the 18-bit result.
   assign distance_q8 = product[pscm_pkg::ProdW-1:16];

endmodule

// ===== hw/rtl/pscm_mode_fsm.sv =====
// ----------------------------------------------------------------------------
// Mode state machine
// Holds the echo counter, the enable and disable stamps, the run mode and
// the last distance, and works out the result of each beat.
// ----------------------------------------------------------------------------
module pscm_mode_fsm (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       echo_valid,
   input  logic [pscm_pkg::DistW-1:0] distance_q8,
   input  pscm_pkg::cfg_type          cfg,
   output pscm_pkg::result_type       result
);

   logic [pscm_pkg::CountW-1:0] echo_count_ff, echo_count_in;
   logic [pscm_pkg::CountW-1:0] enable_stamp_ff, enable_stamp_in;
   logic [pscm_pkg::CountW-1:0] disable_stamp_ff, disable_stamp_in;
   logic [pscm_pkg::DistW-1:0]  last_distance_ff, last_distance_in;
   pscm_pkg::run_mode_type      run_mode_ff, run_mode_in;

   logic [pscm_pkg::CountW-1:0] count_next;
   logic [pscm_pkg::DistW-1:0]  band_lo;
   logic [pscm_pkg::DistW-1:0]  band_hi;
   logic                        in_band;
   logic                        below_near;
   logic [pscm_pkg::CountW-1:0] en_step;
   logic [pscm_pkg::CountW-1:0] dis_step;
   pscm_pkg::run_mode_type      mode_step;
   pscm_pkg::run_mode_type      mode_final;
   logic [pscm_pkg::CountW-1:0] en_final;
   logic                        update;

   // Band bounds in the same fixed-point scale as the distance.
   assign band_lo    = {2'b00, cfg.near_cm, pscm_pkg::FracW'(0)};
   assign band_hi    = {cfg.far_cm, pscm_pkg::FracW'(0)};
   assign in_band    = (band_lo < distance_q8) && (distance_q8 < band_hi);
   assign below_near = distance_q8 < band_lo;
   assign count_next = echo_count_ff + 1'b1;

   // First decision: in the band, start timing from idle, or go back to idle from timing or meter mode.
   always_comb begin
      mode_step = run_mode_ff;
      en_step   = enable_stamp_ff;
      dis_step  = disable_stamp_ff;
      priority if (in_band && run_mode_ff == pscm_pkg::RUN_IDLE &&
                   pscm_pkg::abs_diff(count_next, disable_stamp_ff) > cfg.stop_lockout) begin
         mode_step = pscm_pkg::RUN_TIMING;
         en_step   = count_next;
      end else if (in_band && run_mode_ff != pscm_pkg::RUN_IDLE &&
                   pscm_pkg::abs_diff(count_next, enable_stamp_ff) > cfg.stop_lockout) begin
         mode_step = pscm_pkg::RUN_IDLE;
         dis_step  = count_next;
      end else begin
         // No toggle: the mode holds.
         mode_step = run_mode_ff;
      end
   end

   // Second decision: a closer hand starts meter mode from idle.
   always_comb begin
      mode_final = mode_step;
      en_final   = en_step;
      if (below_near && mode_step == pscm_pkg::RUN_IDLE &&
          pscm_pkg::abs_diff(count_next, dis_step) > cfg.meter_lockout) begin
         mode_final = pscm_pkg::RUN_METER;
         en_final   = count_next;
      end
   end

   // State moves only on a valid echo.
   assign update = advance && echo_valid;

   always_comb begin
      echo_count_in    = echo_count_ff;
      enable_stamp_in  = enable_stamp_ff;
      disable_stamp_in = disable_stamp_ff;
      run_mode_in      = run_mode_ff;
      last_distance_in = last_distance_ff;
      if (update) begin
         echo_count_in    = count_next;
         enable_stamp_in  = en_final;
         disable_stamp_in = dis_step;
         run_mode_in      = mode_final;
         last_distance_in = distance_q8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_count_ff    <= '0;
         enable_stamp_ff  <= '0;
         disable_stamp_ff <= '0;
         run_mode_ff      <= pscm_pkg::RUN_IDLE;
         last_distance_ff <= '0;
      end else begin
         echo_count_ff    <= echo_count_in;
         enable_stamp_ff  <= enable_stamp_in;
         disable_stamp_ff <= disable_stamp_in;
         run_mode_ff      <= run_mode_in;
         last_distance_ff <= last_distance_in;
      end
   end

   // Result of the beat in flight; an invalid echo repeats the old values.
   always_comb begin
      result.distance_q8  = echo_valid ? distance_q8 : last_distance_ff;
      result.mode         = pscm_pkg::mode_code(echo_valid ? mode_final : run_mode_ff);
      result.mode_changed = echo_valid && (mode_final != run_mode_ff);
   end

endmodule

// ===== hw/rtl/proximity_stopwatch_mode_control_unit.sv =====
// ----------------------------------------------------------------------------
// Proximity stopwatch mode control unit
// Each request beat is registered in the input register, its result in the
// result register. Throughput: one beat per cycle when the result channel does
// not stall; the mode state updates as each valid echo moves to the result register.
// Input and result registers part the two channels; while a result waits, one
// more request is held in the input register. Synchronous active-high reset
// clears the mode state, counters and stamps, and loads the register defaults.
// ----------------------------------------------------------------------------
module proximity_stopwatch_mode_control_unit (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_echo_valid,
   input  logic [pscm_pkg::WidthUsW-1:0] req_echo_width_us,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pscm_pkg::DistW-1:0]    rsp_distance_q8,
   output logic [pscm_pkg::ModeW-1:0]    rsp_mode,
   output logic                          rsp_mode_changed,
   // Configuration port
   input  logic                          csr_write_en,
   input  logic [pscm_pkg::CsrIndexW-1:0] csr_index,
   input  logic [pscm_pkg::CsrDataW-1:0] csr_write_data
);

   pscm_pkg::cfg_type            cfg_ff, cfg_in;

   logic                          in_vld_ff, in_vld_in;
   logic                          in_echo_valid_ff;
   logic [pscm_pkg::WidthUsW-1:0] in_width_ff;

   logic                          out_vld_ff, out_vld_in;
   pscm_pkg::result_type          out_ff;

   logic                          req_take;
   logic                          out_load;
   logic                          advance;
   logic [pscm_pkg::DistW-1:0]    distance_q8;
   pscm_pkg::result_type          result;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (pscm_pkg::csr_index_type'(csr_index))
            pscm_pkg::CSR_NEAR_CM:
               cfg_in.near_cm = csr_write_data[pscm_pkg::NearW-1:0];
            pscm_pkg::CSR_FAR_CM:
               cfg_in.far_cm = csr_write_data[pscm_pkg::FarW-1:0];
            pscm_pkg::CSR_STOP_LOCKOUT:
               cfg_in.stop_lockout = csr_write_data[pscm_pkg::CountW-1:0];
            pscm_pkg::CSR_METER_LOCKOUT:
               cfg_in.meter_lockout = csr_write_data[pscm_pkg::CountW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_cm       <= pscm_pkg::NearReset;
         cfg_ff.far_cm        <= pscm_pkg::FarReset;
         cfg_ff.stop_lockout  <= pscm_pkg::StopLockoutReset;
         cfg_ff.meter_lockout <= pscm_pkg::MeterLockoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake: the result register loads when empty or being drained, and
   // the input register moves its beat on whenever the result register loads.
   assign out_load  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_load;
   assign req_stall = in_vld_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = out_load ? advance : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_echo_valid_ff <= req_echo_valid;
         in_width_ff      <= req_echo_width_us;
      end
   end

   pscm_distance u_distance (
      .width_us    (in_width_ff),
      .distance_q8 (distance_q8)
   );

   pscm_mode_fsm u_mode_fsm (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .echo_valid  (in_echo_valid_ff),
      .distance_q8 (distance_q8),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // Result payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_distance_q8  = out_ff.distance_q8;
   assign rsp_mode         = out_ff.mode;
   assign rsp_mode_changed = out_ff.mode_changed;

endmodule
